### design/rsa_modexp_pkg.sv
// ----------------------------------------------------------------------------
// RSA modular exponentiation package
// Shared constants: default datapath width, port field widths, register
// indexes, register reset values and command codes.
// ----------------------------------------------------------------------------
package rsa_modexp_pkg;

  // default bits of modulus, exponents and message inside the datapath
  localparam int RSA_WIDTH_DEFAULT = 32;

  // fixed widths of the port fields
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

  // configuration reset values
  localparam logic [WORD_W-1:0] MODULUS_RST     = 32'd33;
  localparam logic [WORD_W-1:0] PUBLIC_EXP_RST  = 32'd3;
  localparam logic [WORD_W-1:0] PRIVATE_EXP_RST = 32'd7;

  // command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

endpackage

### design/rsa_modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// RSA modular exponentiation top level
// Computes message^exponent mod modulus by right-to-left square-and-multiply
// on one shared modular adder under a small sequencer.
// ----------------------------------------------------------------------------
// One word is taken at a time; s_tready is high only while the sequencer is
// idle, and a finished result sits in the output register so the next word
// can be taken before it is read. All work runs through one modular adder:
// the message is first reduced bit by bit, then each modular multiplication
// is a shift-and-add over the WIDTH bits of one operand, with a doubling
// step per bit and an add step for each set bit, followed by a bookkeeping
// step. An exponent with k significant bits and p set bits needs k-1
// squarings and p multiplications. A zero modulus makes all arithmetic
// wrap at 2^WIDTH; a zero exponent gives 1.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_top
  import rsa_modexp_pkg::*;
#(
  parameter int WIDTH = RSA_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // input words
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [WORD_W-1:0]    s_tdata,   // [31:0] message
  input  logic                 s_tuser,   // [0] command
  input  logic                 s_tlast,   // block_end
  // result words
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WORD_W-1:0]    m_tdata,   // [31:0] value
  output logic                 m_tlast    // last_of_block
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOP = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // kind of the pass running through the loop
  localparam logic [1:0] K_RED  = 2'd0;
  localparam logic [1:0] K_RES  = 2'd1;
  localparam logic [1:0] K_BASE = 2'd2;

  // configuration registers
  logic [WORD_W-1:0] modulus;
  logic [WORD_W-1:0] public_exponent;
  logic [WORD_W-1:0] private_exponent;

  // sequencer and datapath registers
  logic [1:0]       state;
  logic [1:0]       kind;
  logic             phase;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] ex;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] res;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] bsh;
  logic             last;

  logic [WIDTH-1:0] mod_w;
  logic [WIDTH-1:0] add_y;
  logic [WIDTH-1:0] add_sum;
  logic             out_free;

  assign mod_w    = WIDTH'(modulus);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // second operand: doubling, then the added bit or the base
  assign add_y = !phase ? acc : ((kind == K_RED) ? WIDTH'(1) : base);

  rsa_modexp_addmod #(
    .WIDTH (WIDTH)
  ) u_addmod (
    .x   (acc),
    .y   (add_y),
    .m   (mod_w),
    .sum (add_sum)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= MODULUS_RST;
      public_exponent  <= PUBLIC_EXP_RST;
      private_exponent <= PRIVATE_EXP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS:     modulus          <= cfg_data;
        CFG_PUBLIC_EXP:  public_exponent  <= cfg_data;
        CFG_PRIVATE_EXP: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      kind     <= K_RED;
      phase    <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result wins over the read of the old one
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_LOOP;
            kind  <= K_RED;
            phase <= 1'b0;
            cnt   <= CW'(WIDTH - 1);
          end
        end
        ST_LOOP: begin
          if (!phase && bsh[WIDTH-1]) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (cnt == '0) state <= ST_POST;
            else cnt <= cnt - 1'b1;
          end
        end
        ST_POST: begin
          cnt   <= CW'(WIDTH - 1);
          phase <= 1'b0;
          if (kind == K_RES) begin
            if (ex[WIDTH-1:1] == '0) state <= ST_OUT;
            else begin
              state <= ST_LOOP;
              kind  <= K_BASE;
            end
          end else if (ex == '0) begin
            state <= ST_OUT;
          end else begin
            state <= ST_LOOP;
            kind  <= ex[0] ? K_RES : K_BASE;
          end
        end
        ST_OUT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ex   <= WIDTH'((s_tuser == CMD_DECRYPT) ? private_exponent : public_exponent);
          bsh  <= WIDTH'(s_tdata);
          acc  <= '0;
          res  <= WIDTH'(1);
          last <= s_tlast;
        end
      end
      ST_LOOP: begin
        acc <= add_sum;
        if (phase || !bsh[WIDTH-1]) bsh <= bsh << 1;
      end
      ST_POST: begin
        acc <= '0;
        if (kind == K_RES) begin
          res <= acc;
          ex  <= ex >> 1;
          bsh <= base;
        end else begin
          base <= acc;
          if (ex != '0) begin
            if (ex[0]) bsh <= res;
            else begin
              ex  <= ex >> 1;
              bsh <= acc;
            end
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= WORD_W'(res);
          m_tlast <= last;
        end
      end
      default: ;
    endcase
  end

  // an accepted word always starts the message reduction
  a_accept_starts_reduce: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_LOOP && kind == K_RED && !phase))
    else $error("accepted word did not start reduction");

  // a result only appears from the output state
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUT))
    else $error("result raised outside the output state");

  // the add phase only exists inside the bit loop
  a_phase_in_loop: assert property (@(posedge clk) disable iff (rst)
    phase |-> (state == ST_LOOP))
    else $error("add phase set outside the loop");

  // no new word is taken while a pass is in flight
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOP && cnt != '0) |=> !s_tready)
    else $error("ready raised in the middle of a pass");

endmodule

### design/rsa_modexp_addmod.sv
// ----------------------------------------------------------------------------
// Modular adder
// Shared arithmetic unit: (x + y) mod m with one add and one compare and
// subtract. Needs x < m and y <= m. A modulus of zero gives the sum
// wrapped to WIDTH bits.
// ----------------------------------------------------------------------------
module rsa_modexp_addmod #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic [WIDTH-1:0] sum
);

  logic [WIDTH:0] raw;
  logic [WIDTH:0] diff;

  // sum one bit wider, then one conditional subtract
  assign raw  = {1'b0, x} + {1'b0, y};
  assign diff = raw - {1'b0, m};
  assign sum  = (raw >= {1'b0, m}) ? diff[WIDTH-1:0] : raw[WIDTH-1:0];

endmodule
